// ===== rtl/core/ted_pkg.sv =====
package ted_pkg;

   localparam int TED_DELAY_DEPTH = 131072;
   localparam int TED_CHANNELS    = 2;
   localparam int TED_SAMPLE_BITS = 24;

   // register indexes on the csr port
   localparam logic [2:0] CSR_BASE_DELAY    = 3'd0;
   localparam logic [2:0] CSR_WOBBLE_DEPTH  = 3'd1;
   localparam logic [2:0] CSR_LFO_INCREMENT = 3'd2;
   localparam logic [2:0] CSR_FEEDBACK_GAIN = 3'd3;
   localparam logic [2:0] CSR_MIX_LEVEL     = 3'd4;
   localparam logic [2:0] CSR_LOWPASS_COEF  = 3'd5;
   localparam logic [2:0] CSR_SAT_AMOUNT    = 3'd6;
   localparam logic [2:0] CSR_CHANNELS_USED = 3'd7;

   localparam logic [24:0] RST_BASE_DELAY    = 25'd5529600;
   localparam logic [17:0] RST_WOBBLE_DEPTH  = 18'd36864;
   localparam logic [31:0] RST_LFO_INCREMENT = 32'd35791;
   localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd36045;
   localparam logic [16:0] RST_MIX_LEVEL     = 17'd22938;
   localparam logic [15:0] RST_LOWPASS_COEF  = 16'd29878;
   localparam logic [16:0] RST_SAT_AMOUNT    = 17'd19661;
   localparam logic [1:0]  RST_CHANNELS_USED = 2'd2;

   // drive at or below this bypasses the saturator
   localparam logic [16:0] SAT_BYPASS_LIMIT = 17'd6;
   localparam logic [16:0] UNITY_Q16        = 17'h10000;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LFO_PT, ST_LFO_MUL, ST_LFO_SUM, ST_WOB_MUL,
      ST_DELAY, ST_RPOS, ST_RD0, ST_RD1, ST_INT1, ST_LP0, ST_LP1, ST_LP2,
      ST_SAT0, ST_SAT1, ST_DIV_GO, ST_DIV_WAIT, ST_FB, ST_WRITE, ST_MIX0,
      ST_MIX1, ST_DONE
   } ted_state_type;

   // quarter-wave sine, Q1.15
   function automatic logic [15:0] ted_sine_q(input logic [5:0] r);
      logic [15:0] v;
      case (r)
         6'd0:  v = 16'd0;     6'd1:  v = 16'd1608;  6'd2:  v = 16'd3212;
         6'd3:  v = 16'd4808;  6'd4:  v = 16'd6393;  6'd5:  v = 16'd7962;
         6'd6:  v = 16'd9512;  6'd7:  v = 16'd11039; 6'd8:  v = 16'd12539;
         6'd9:  v = 16'd14010; 6'd10: v = 16'd15446; 6'd11: v = 16'd16846;
         6'd12: v = 16'd18204; 6'd13: v = 16'd19519; 6'd14: v = 16'd20787;
         6'd15: v = 16'd22005; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
         6'd18: v = 16'd25329; 6'd19: v = 16'd26319; 6'd20: v = 16'd27245;
         6'd21: v = 16'd28105; 6'd22: v = 16'd28898; 6'd23: v = 16'd29621;
         6'd24: v = 16'd30273; 6'd25: v = 16'd30852; 6'd26: v = 16'd31356;
         6'd27: v = 16'd31785; 6'd28: v = 16'd32137; 6'd29: v = 16'd32412;
         6'd30: v = 16'd32609; 6'd31: v = 16'd32728; 6'd32: v = 16'd32767;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // one of 128 points of a full sine turn
   function automatic logic signed [16:0] ted_sine_point(input logic [6:0] k);
      logic [5:0] r;
      logic signed [16:0] s;
      r = k[5] ? (6'd32 - {1'b0, k[4:0]}) : {1'b0, k[4:0]};
      s = $signed({1'b0, ted_sine_q(r)});
      return k[6] ? -s : s;
   endfunction

   // tanh at steps of 1/16, Q0.16
   function automatic logic [15:0] ted_tanh_q(input logic [5:0] i);
      logic [15:0] v;
      case (i)
         6'd0:  v = 16'd0;     6'd1:  v = 16'd4091;  6'd2:  v = 16'd8150;
         6'd3:  v = 16'd12146; 6'd4:  v = 16'd16051; 6'd5:  v = 16'd19840;
         6'd6:  v = 16'd23485; 6'd7:  v = 16'd26975; 6'd8:  v = 16'd30286;
         6'd9:  v = 16'd33404; 6'd10: v = 16'd36347; 6'd11: v = 16'd39084;
         6'd12: v = 16'd41625; 6'd13: v = 16'd43973; 6'd14: v = 16'd46131;
         6'd15: v = 16'd48108; 6'd16: v = 16'd49911; 6'd17: v = 16'd51552;
         6'd18: v = 16'd53038; 6'd19: v = 16'd54382; 6'd20: v = 16'd55593;
         6'd21: v = 16'd56682; 6'd22: v = 16'd57660; 6'd23: v = 16'd58536;
         6'd24: v = 16'd59320; 6'd25: v = 16'd60019; 6'd26: v = 16'd60644;
         6'd27: v = 16'd61199; 6'd28: v = 16'd61694; 6'd29: v = 16'd62134;
         6'd30: v = 16'd62525; 6'd31: v = 16'd62870; 6'd32: v = 16'd63178;
         default: v = 16'd63178;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/ted_delay_mem.sv =====
module ted_delay_mem #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_q [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_q[rd_addr];
   end

endmodule

// ===== rtl/core/ted_divider.sv =====
module ted_divider #(
   parameter int DW = 39,
   parameter int VW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [VW:0]   trial;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_ff <= VW'(trial - {1'b0, divisor});
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= VW'(trial);
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/tape_echo_delay_line_unit.sv =====
// Modulated feedback echo. Each req item carries one signed sample and its channel; each
// produces exactly one rsp item, the saturated dry/wet mix. The delay line is read at a
// fractional position (base delay plus LFO wobble, Q.8 samples), linearly interpolated,
// low-passed, soft-saturated and fed back into the line together with the input. An item
// runs through a sequencer around one delay memory. The saturator divides with a bit-serial
// divider, which needs one cycle per dividend bit, and is bypassed for a drive of 6 or
// less. One item is in work at a time; a finished result waits in the rsp register while
// the next item is taken. After reset the delay memory is cleared one entry a cycle, all
// CHANNELS * DELAY_DEPTH entries (262144 by default), and no item is taken meanwhile;
// csr writes are taken at all times and must only be made while the block is idle.
module tape_echo_delay_line_unit #(
   parameter int DELAY_DEPTH = ted_pkg::TED_DELAY_DEPTH,
   parameter int CHANNELS    = ted_pkg::TED_CHANNELS,
   parameter int SAMPLE_BITS = ted_pkg::TED_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_mixed_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   import ted_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int FB    = SB - 1;
   localparam int DAW   = $clog2(DELAY_DEPTH);
   localparam int PW    = DAW + 8;
   localparam int SW    = DAW + 9;
   localparam int DLW   = (DAW + 10 > 28) ? DAW + 10 : 28;
   localparam int TOTAL = CHANNELS * DELAY_DEPTH;
   localparam int AW    = $clog2(TOTAL);
   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ACW   = SB + 20;
   localparam int DQW   = 16 + FB;

   localparam logic signed [DLW-1:0] DLY_MIN = DLW'(256);
   localparam logic signed [DLW-1:0] DLY_MAX = DLW'((DELAY_DEPTH - 4) * 256);
   localparam logic [SW-1:0]         SPAN    = SW'(DELAY_DEPTH * 256);
   localparam logic [DAW-1:0]        LAST_W  = DAW'(DELAY_DEPTH - 1);
   localparam logic [AW-1:0]         LAST_A  = AW'(TOTAL - 1);
   localparam logic [AW-1:0]         LINE_SZ = AW'(DELAY_DEPTH);
   localparam logic [3:0]            CH_MAX  = 4'(CHANNELS);
   localparam logic signed [ACW-1:0] SMAX    = ACW'((64'sd1 <<< FB) - 64'sd1);
   localparam logic signed [ACW-1:0] SMIN    = -SMAX - ACW'(1);
   localparam logic [DQW-1:0]        QMAX    = DQW'((64'd1 << FB) - 64'd1);

   function automatic logic signed [SB-1:0] sat_fn(input logic signed [ACW-1:0] v);
      logic signed [ACW-1:0] r;
      r = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return SB'(r);
   endfunction

   // ---------------------------------------------------------------- csr file
   logic [24:0] base_delay_ff;
   logic [17:0] wobble_depth_ff;
   logic [31:0] lfo_increment_ff;
   logic [15:0] feedback_gain_ff;
   logic [16:0] mix_level_ff;
   logic [15:0] lowpass_coef_ff;
   logic [16:0] sat_amount_ff;
   logic [1:0]  channels_used_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff    <= RST_BASE_DELAY;
         wobble_depth_ff  <= RST_WOBBLE_DEPTH;
         lfo_increment_ff <= RST_LFO_INCREMENT;
         feedback_gain_ff <= RST_FEEDBACK_GAIN;
         mix_level_ff     <= RST_MIX_LEVEL;
         lowpass_coef_ff  <= RST_LOWPASS_COEF;
         sat_amount_ff    <= RST_SAT_AMOUNT;
         channels_used_ff <= RST_CHANNELS_USED;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_DELAY:    base_delay_ff    <= csr_data[24:0];
            CSR_WOBBLE_DEPTH:  wobble_depth_ff  <= csr_data[17:0];
            CSR_LFO_INCREMENT: lfo_increment_ff <= csr_data;
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_data[15:0];
            CSR_MIX_LEVEL:     mix_level_ff     <= csr_data[16:0];
            CSR_LOWPASS_COEF:  lowpass_coef_ff  <= csr_data[15:0];
            CSR_SAT_AMOUNT:    sat_amount_ff    <= csr_data[16:0];
            CSR_CHANNELS_USED: channels_used_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   ted_state_type state_ff, state_in;

   logic [AW-1:0]            clr_ff;
   logic [31:0]              phase_ff;
   logic [DAW-1:0]           wpos_ff [CHANNELS];
   logic signed [SB-1:0]     lpm_ff  [CHANNELS];

   logic signed [SB-1:0]     x_ff;
   logic [CHW-1:0]           c_ff;
   logic signed [ACW-1:0]    acc_ff;
   logic signed [16:0]       s0_ff;
   logic signed [16:0]       sd_ff;
   logic signed [16:0]       lfo_ff;
   logic [PW-1:0]            dly_ff;
   logic [DAW-1:0]           i0_ff;
   logic [DAW-1:0]           i1_ff;
   logic [7:0]               f8_ff;
   logic signed [SB-1:0]     dl_ff;
   logic signed [SB-1:0]     lp_ff;
   logic                     neg_ff;
   logic [15:0]              t0_ff;
   logic [15:0]              td_ff;
   logic [15:0]              fr_ff;
   logic [15:0]              t_ff;
   logic signed [SB-1:0]     fb_ff;

   logic                     rsp_valid_ff;
   logic signed [SB-1:0]     rsp_data_ff;

   // ---------------------------------------------------------------- datapath
   logic                     div_start;
   logic                     div_done;
   logic [DQW-1:0]           div_q;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [SB-1:0]            mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [SB-1:0]            mem_rdata;

   logic                     req_take;
   logic                     rsp_free;
   logic [AW-1:0]            line_base;
   logic [DAW-1:0]           w_cur;
   logic [3:0]               n_eff;
   logic signed [DLW-1:0]    dly_sum;
   logic [SW-1:0]            rpos_sum;
   logic [SW-1:0]            rpos;
   logic [8:0]               inv8;
   logic signed [SB-1:0]     dl_w;
   logic signed [SB-1:0]     lp_w;
   logic signed [SB:0]       u_w;
   logic [SB:0]              mag_w;
   logic [5:0]               idx_w;
   logic [FB+11:0]           frw_w;
   logic [31:0]              tprod_w;
   logic [16:0]              wet_w;
   logic [16:0]              lp_keep;
   logic [16:0]              dry_w;
   logic signed [SB-1:0]     fb_w;
   logic signed [SB-1:0]     wr_val;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign line_base = AW'(c_ff) * LINE_SZ;
   assign w_cur     = wpos_ff[c_ff];

   // channels in use: none acts as one, too many act as all
   assign n_eff = (channels_used_ff == 2'd0) ? 4'd1 :
                  ((4'(channels_used_ff) > CH_MAX) ? CH_MAX : 4'(channels_used_ff));

   // delay = base + wobble * lfo, clamped to the usable line
   always_comb begin
      dly_sum = DLW'($signed({1'b0, base_delay_ff})) + DLW'(acc_ff >>> 15);
      if (dly_sum < DLY_MIN) begin
         dly_sum = DLY_MIN;
      end else if (dly_sum > DLY_MAX) begin
         dly_sum = DLY_MAX;
      end
   end

   // read position behind the write pointer, wrapped once
   assign rpos_sum = SW'({w_cur, 8'd0}) + SPAN - SW'(dly_ff);
   assign rpos     = (rpos_sum >= SPAN) ? (rpos_sum - SPAN) : rpos_sum;

   assign inv8    = 9'd256 - 9'(f8_ff);
   assign dl_w    = SB'(acc_ff >>> 8);
   assign lp_w    = SB'(acc_ff >>> 16);
   assign lp_keep = UNITY_Q16 - 17'(lowpass_coef_ff);
   assign u_w     = (SB+1)'(acc_ff >>> 16);
   // magnitude of the most negative drive wraps to the right unsigned value
   assign mag_w   = u_w[SB] ? (SB+1)'(-u_w) : (SB+1)'(u_w);
   assign idx_w   = mag_w[SB:FB-4];
   assign frw_w   = {mag_w[FB-5:0], 16'd0} >> (FB - 4);
   assign tprod_w = td_ff * fr_ff;
   assign wet_w   = (mix_level_ff > UNITY_Q16) ? UNITY_Q16 : mix_level_ff;
   assign dry_w   = UNITY_Q16 - wet_w;
   assign wr_val  = sat_fn(ACW'(x_ff) + ACW'(acc_ff >>> 16));

   always_comb begin
      if (neg_ff) begin
         fb_w = (div_q > QMAX) ? SB'(SMIN) : SB'(-$signed({1'b0, div_q}));
      end else begin
         fb_w = (div_q > QMAX) ? SB'(SMAX) : SB'(div_q);
      end
   end

   // one memory port pair: clearing sweep or the item's write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = line_base + AW'(w_cur);
      mem_wdata = wr_val;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_WRITE) begin
         mem_we = 1'b1;
      end
   end

   assign mem_raddr = line_base + AW'((state_ff == ST_RD0) ? i0_ff : i1_ff);
   assign div_start = (state_ff == ST_DIV_GO);

   ted_delay_mem #(
      .WIDTH (SB),
      .DEPTH (TOTAL),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ted_divider #(
      .DW (DQW),
      .VW (17)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({t_ff, {FB{1'b0}}}),
      .divisor  (sat_amount_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_ff == LAST_A) state_in = ST_IDLE;
         ST_IDLE:     if (req_take) state_in = ST_LFO_PT;
         ST_LFO_PT:   state_in = ST_LFO_MUL;
         ST_LFO_MUL:  state_in = ST_LFO_SUM;
         ST_LFO_SUM:  state_in = ST_WOB_MUL;
         ST_WOB_MUL:  state_in = ST_DELAY;
         ST_DELAY:    state_in = ST_RPOS;
         ST_RPOS:     state_in = ST_RD0;
         ST_RD0:      state_in = ST_RD1;
         ST_RD1:      state_in = ST_INT1;
         ST_INT1:     state_in = ST_LP0;
         ST_LP0:      state_in = ST_LP1;
         ST_LP1:      state_in = ST_LP2;
         ST_LP2:      state_in = ST_SAT0;
         ST_SAT0:     state_in = (sat_amount_ff <= SAT_BYPASS_LIMIT) ? ST_FB : ST_SAT1;
         ST_SAT1:     state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_FB;
         ST_FB:       state_in = ST_WRITE;
         ST_WRITE:    state_in = ST_MIX0;
         ST_MIX0:     state_in = ST_MIX1;
         ST_MIX1:     state_in = ST_DONE;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control state: clear sweep, write pointers, lowpass memory, LFO, rsp flag
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CHANNELS; k++) begin
            wpos_ff[k] <= '0;
            lpm_ff[k]  <= '0;
         end
      end else begin
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == ST_LP2) begin
            lpm_ff[c_ff] <= lp_w;
         end
         if (state_ff == ST_WRITE) begin
            wpos_ff[c_ff] <= (w_cur == LAST_W) ? '0 : w_cur + DAW'(1);
            // advance the LFO after the last channel in use of a frame
            if (4'(c_ff) == n_eff - 4'd1) begin
               phase_ff <= phase_ff + lfo_increment_ff;
            end
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers of one item
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x_ff <= req_sample;
            c_ff <= (CHANNELS > 1) ? CHW'(req_channel) : '0;
         end
         ST_LFO_PT: begin
            s0_ff <= ted_sine_point(phase_ff[31:25]);
            sd_ff <= ted_sine_point(phase_ff[31:25] + 7'd1)
                     - ted_sine_point(phase_ff[31:25]);
         end
         ST_LFO_MUL:  acc_ff <= ACW'(sd_ff) * ACW'($signed({1'b0, phase_ff[24:9]}));
         ST_LFO_SUM:  lfo_ff <= s0_ff + 17'(acc_ff >>> 16);
         ST_WOB_MUL:  acc_ff <= ACW'($signed({1'b0, wobble_depth_ff})) * ACW'(lfo_ff);
         ST_DELAY:    dly_ff <= PW'(dly_sum);
         ST_RPOS: begin
            i0_ff <= rpos[DAW+7:8];
            i1_ff <= (rpos[DAW+7:8] == LAST_W) ? '0 : rpos[DAW+7:8] + DAW'(1);
            f8_ff <= rpos[7:0];
         end
         ST_RD0: ;
         ST_RD1: begin
            acc_ff <= ACW'($signed(mem_rdata)) * ACW'($signed({1'b0, inv8}));
         end
         ST_INT1: begin
            acc_ff <= acc_ff + ACW'($signed(mem_rdata)) * ACW'($signed({1'b0, f8_ff}));
         end
         ST_LP0: begin
            dl_ff  <= dl_w;
            acc_ff <= ACW'(dl_w) * ACW'($signed({1'b0, lp_keep}));
         end
         ST_LP1: begin
            acc_ff <= acc_ff + ACW'(lpm_ff[c_ff]) * ACW'($signed({1'b0, lowpass_coef_ff}));
         end
         ST_LP2: begin
            lp_ff  <= lp_w;
            acc_ff <= ACW'(lp_w) * ACW'($signed({1'b0, sat_amount_ff}));
         end
         ST_SAT0: begin
            fb_ff  <= lp_ff;
            neg_ff <= u_w[SB];
            fr_ff  <= frw_w[15:0];
            // beyond the table hold the last entry
            if (idx_w >= 6'd32) begin
               t0_ff <= ted_tanh_q(6'd32);
               td_ff <= '0;
            end else begin
               t0_ff <= ted_tanh_q(idx_w);
               td_ff <= ted_tanh_q(idx_w + 6'd1) - ted_tanh_q(idx_w);
            end
         end
         ST_SAT1:     t_ff <= t0_ff + tprod_w[31:16];
         ST_DIV_GO: ;
         ST_DIV_WAIT: if (div_done) fb_ff <= fb_w;
         ST_FB:       acc_ff <= ACW'(fb_ff) * ACW'($signed({1'b0, feedback_gain_ff}));
         ST_WRITE: ;
         ST_MIX0:     acc_ff <= ACW'(x_ff) * ACW'($signed({1'b0, dry_w}));
         ST_MIX1:     acc_ff <= acc_ff + ACW'(dl_ff) * ACW'($signed({1'b0, wet_w}));
         ST_DONE:     if (rsp_free) rsp_data_ff <= sat_fn(ACW'(acc_ff >>> 16));
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // an accepted item keeps the input side closed on the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input taken again straight after an item");

   // a result appears only when the sequencer finishes an item
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   // the divider finishes only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider result arrived unexpectedly");

endmodule
